/* sv/arfs_pkg.sv */
// Shared types and constants for the awk-style record and field splitter.
package arfs_pkg;

	localparam int unsigned NUM_W    = 9;
	localparam int unsigned MAX_EV   = 4;
	localparam int unsigned EVCNT_W  = 3;
	localparam int unsigned EVIDX_W  = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	typedef enum logic [1:0] {
		EV_BYTE = 2'd0,
		EV_FEND = 2'd1,
		EV_REND = 2'd2
	} ev_kind_t;

	// Field split modes; the two unused codes behave as one field per character.
	localparam logic [1:0] FM_WS   = 2'd0;
	localparam logic [1:0] FM_SEP  = 2'd1;

	localparam logic RM_PARA = 1'b0;
	localparam logic RM_SEP  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_MODE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SEP   = 2'd3;

	typedef struct packed {
		logic       record_mode;
		logic [7:0] record_sep;
		logic [1:0] field_mode;
		logic [7:0] field_sep;
	} cfg_t;

	typedef struct packed {
		logic             fields_overflow;
		logic [NUM_W-1:0] field_count;
		logic [NUM_W-1:0] field_number;
		logic [7:0]       out_byte;
		ev_kind_t         event_kind;
	} evt_t;

	// All events caused by one input beat.
	typedef struct packed {
		evt_t [MAX_EV-1:0]  ev;
		logic [EVCNT_W-1:0] cnt;
	} grp_t;

endpackage

/* sv/arfs_step.sv */
// Splitter state and the per-byte event generation.
module arfs_step
	import arfs_pkg::*;
#(
	parameter int unsigned MAX_FIELDS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	input  cfg_t       cfg,
	output grp_t       grp
);

	localparam int unsigned CNT_W = $clog2(MAX_FIELDS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FIELDS);

	typedef struct packed {
		logic             rec_act;
		logic             fld_act;
		logic             held_nl;
		logic             ovf;
		logic [CNT_W-1:0] seen;
	} st_t;

	typedef struct packed {
		st_t  st;
		grp_t g;
	} work_t;

	st_t   st_q;
	work_t w;

	function automatic work_t f_emit(input work_t wi, input ev_kind_t k, input logic [7:0] b,
		input logic [NUM_W-1:0] num, input logic [NUM_W-1:0] cnt, input logic ovf);
		work_t wo;
		evt_t  e;
		wo = wi;
		e.event_kind      = k;
		e.out_byte        = b;
		e.field_number    = num;
		e.field_count     = cnt;
		e.fields_overflow = ovf;
		if (wi.g.cnt < EVCNT_W'(MAX_EV)) begin
			wo.g.ev[wi.g.cnt[EVIDX_W-1:0]] = e;
			wo.g.cnt = wi.g.cnt + 1'b1;
		end
		return wo;
	endfunction

	function automatic work_t f_start_field(input work_t wi);
		work_t wo;
		wo = wi;
		wo.st.fld_act = 1'b1;
		if (wi.st.seen < MAX_CNT)
			wo.st.seen = wi.st.seen + 1'b1;
		else
			wo.st.ovf = 1'b1;
		return wo;
	endfunction

	function automatic work_t f_end_field(input work_t wi);
		work_t wo;
		wo = wi;
		if (wi.st.fld_act && !wi.st.ovf)
			wo = f_emit(wi, EV_FEND, 8'd0, NUM_W'(wi.st.seen), '0, 1'b0);
		wo.st.fld_act = 1'b0;
		return wo;
	endfunction

	function automatic work_t f_field_byte(input work_t wi, input logic [7:0] c);
		work_t wo;
		wo = wi;
		if (!wi.st.ovf)
			wo = f_emit(wi, EV_BYTE, c, NUM_W'(wi.st.seen), '0, 1'b0);
		return wo;
	endfunction

	function automatic work_t f_end_record(input work_t wi);
		work_t wo;
		wo = f_end_field(wi);
		wo = f_emit(wo, EV_REND, 8'd0, '0, NUM_W'(wo.st.seen), wo.st.ovf);
		wo.st = '0;
		return wo;
	endfunction

	// One byte that belongs to the current record.
	function automatic work_t f_feed(input work_t wi, input logic [7:0] c, input cfg_t cf);
		work_t wo;
		logic  first;
		logic  is_sep;
		wo = wi;
		first = !wi.st.rec_act;
		wo.st.rec_act = 1'b1;
		is_sep = (c == cf.field_sep) || (cf.record_mode == RM_PARA && c == CH_NL);
		if (cf.field_mode == FM_WS) begin
			if (c == CH_SP || c == CH_TAB || c == CH_NL) begin
				wo = f_end_field(wo);
			end else begin
				if (!wo.st.fld_act)
					wo = f_start_field(wo);
				wo = f_field_byte(wo, c);
			end
		end else if (cf.field_mode == FM_SEP) begin
			if (first || !wo.st.fld_act)
				wo = f_start_field(wo);
			if (is_sep) begin
				wo = f_end_field(wo);
				wo = f_start_field(wo);
			end else begin
				wo = f_field_byte(wo, c);
			end
		end else begin
			wo = f_start_field(wo);
			wo = f_field_byte(wo, c);
			wo = f_end_field(wo);
		end
		return wo;
	endfunction

	always_comb begin
		w    = '0;
		w.st = st_q;
		if (end_of_input) begin
			if (w.st.held_nl && cfg.record_mode == RM_SEP) begin
				w.st.held_nl = 1'b0;
				w = f_feed(w, CH_NL, cfg);
			end
			w.st.held_nl = 1'b0;
			if (w.st.rec_act)
				w = f_end_record(w);
		end else if (cfg.record_mode == RM_PARA) begin
			if (w.st.held_nl) begin
				w.st.held_nl = 1'b0;
				if (in_byte == CH_NL) begin
					w = f_end_record(w);
				end else begin
					w = f_feed(w, CH_NL, cfg);
					w = f_feed(w, in_byte, cfg);
				end
			end else if (in_byte == CH_NL) begin
				if (w.st.rec_act)
					w.st.held_nl = 1'b1;
			end else begin
				w = f_feed(w, in_byte, cfg);
			end
		end else begin
			// A newline held over from paragraph mode becomes an ordinary byte.
			if (w.st.held_nl) begin
				w.st.held_nl = 1'b0;
				w = f_feed(w, CH_NL, cfg);
			end
			if (in_byte == cfg.record_sep)
				w = f_end_record(w);
			else
				w = f_feed(w, in_byte, cfg);
		end
	end

	assign grp = w.g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= w.st;
		end
	end

endmodule

/* sv/arfs_evq.sv */
// Result register holding one beat's events and handing them out one per cycle while ev_ready is high.
module arfs_evq
	import arfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  grp_t grp_in,
	output logic room,
	output logic ev_valid,
	input  logic ev_ready,
	output evt_t ev,
	output logic ev_last
);

	evt_t [MAX_EV-1:0]  ev_q;
	logic [EVCNT_W-1:0] cnt_q;
	logic [EVIDX_W-1:0] idx_q;
	logic               take;

	assign ev_valid = (cnt_q != '0);
	assign ev       = ev_q[idx_q];
	assign ev_last  = (EVCNT_W'(idx_q) + 1'b1 == cnt_q);
	assign take     = ev_valid && ev_ready;
	// A new beat may enter when no events are held, or once the last held event leaves in this cycle.
	assign room     = !ev_valid || (take && ev_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= grp_in.cnt;
			idx_q <= '0;
		end else if (take) begin
			if (ev_last) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			ev_q <= grp_in.ev;
	end

endmodule

/* sv/awk_record_field_splitter.sv */
// Top level of the awk-style record and field splitter.
//
//  channel   dir  tdata                                   tuser       tlast
//  s_axis    in   [7:0] in_byte                           -           end_of_input
//  m_axis    out  [7:0] out_byte, [16:8] field_number,    event_kind  last
//                 [25:17] field_count, [26] overflow
//  cfg       in   cfg_we / cfg_addr / cfg_wdata, no read-back
//
// Each input beat is decoded in the cycle it is accepted and its zero to four
// events land in the result register; one byte per cycle enters while each
// beat makes at most one event and m_axis is ready. Output runs one event per
// cycle while m_tready is high. Reset clears the split state and restores the
// register defaults. A stalled m_axis holds the current event, and s_tready
// drops until the last held event is taken.
module awk_record_field_splitter
	import arfs_pkg::*;
#(
	parameter int unsigned MAX_FIELDS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] in_byte
	input  logic                  s_tlast,   // end_of_input
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // out_byte, field_number, field_count, overflow
	output logic [1:0]            m_tuser,   // [1:0] event_kind
	output logic                  m_tlast,   // last event of the input beat
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	grp_t grp;
	evt_t ev;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.record_mode <= RM_SEP;
			cfg_q.record_sep  <= CH_NL;
			cfg_q.field_mode  <= FM_WS;
			cfg_q.field_sep   <= CH_SP;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_RECORD_MODE: cfg_q.record_mode <= cfg_wdata[0];
				CFG_RECORD_SEP:  cfg_q.record_sep  <= cfg_wdata;
				CFG_FIELD_MODE:  cfg_q.field_mode  <= cfg_wdata[1:0];
				CFG_FIELD_SEP:   cfg_q.field_sep   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign accept = s_tvalid && s_tready;

	arfs_step #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (s_tdata),
		.end_of_input(s_tlast),
		.cfg         (cfg_q),
		.grp         (grp)
	);

	arfs_evq u_evq (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.grp_in  (grp),
		.room    (s_tready),
		.ev_valid(m_tvalid),
		.ev_ready(m_tready),
		.ev      (ev),
		.ev_last (m_tlast)
	);

	assign m_tdata = {5'd0, ev.fields_overflow, ev.field_count, ev.field_number, ev.out_byte};
	assign m_tuser = ev.event_kind;

endmodule

/* tb/field_split_checker.sv */
// Checker for the record and field splitter: predicts the event stream and compares it.
`timescale 1ns / 100ps
module field_split_checker
	import arfs_pkg::*;
#(
	parameter int unsigned MAX_FIELDS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [7:0]            s_tdata,
	input  logic                  s_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [31:0]           m_tdata,
	input  logic [1:0]            m_tuser,
	input  logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct packed {
		evt_t ev;
		logic last;
	} split_evt_t;

	split_evt_t  expected_events[$];
	split_evt_t  beat_events[$];

	// Register copy as the block should hold it.
	logic        rec_mode;
	logic [7:0]  rec_sep;
	logic [1:0]  fld_mode;
	logic [7:0]  fld_sep;

	// Splitting state.
	logic        rec_open;
	logic        fld_open;
	logic        nl_held;
	logic        ovf;
	int unsigned nfields;
	int unsigned events_seen;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: output beat %0d, %s: got %0h, expected %0h",
			$time, events_seen, what, got, want);
		mismatches++;
	endtask

	task automatic push_event(input ev_kind_t kind, input logic [7:0] b,
			input int unsigned num, input int unsigned cnt, input logic o);
		split_evt_t e;
		e.ev.event_kind      = kind;
		e.ev.out_byte        = b;
		e.ev.field_number    = num[NUM_W-1:0];
		e.ev.field_count     = cnt[NUM_W-1:0];
		e.ev.fields_overflow = o;
		e.last               = 1'b0;
		beat_events.insert(beat_events.size(), e);
	endtask

	// Fields past the limit are counted as overflow and produce no events.
	task automatic open_field();
		fld_open = 1'b1;
		if (nfields < MAX_FIELDS)
			nfields++;
		else
			ovf = 1'b1;
	endtask

	task automatic close_field();
		if (fld_open && !ovf)
			push_event(EV_FEND, 8'h00, nfields, 0, 1'b0);
		fld_open = 1'b0;
	endtask

	task automatic field_byte(input logic [7:0] c);
		if (!ovf)
			push_event(EV_BYTE, c, nfields, 0, 1'b0);
	endtask

	task automatic close_record();
		close_field();
		push_event(EV_REND, 8'h00, 0, nfields, ovf);
		rec_open = 1'b0;
		fld_open = 1'b0;
		nl_held  = 1'b0;
		nfields  = 0;
		ovf      = 1'b0;
	endtask

	task automatic take_byte(input logic [7:0] c);
		logic first;
		logic is_sep;
		first    = !rec_open;
		rec_open = 1'b1;
		case (fld_mode)
			FM_WS: begin
				if (c == CH_SP || c == CH_TAB || c == CH_NL) begin
					close_field();
				end else begin
					if (!fld_open)
						open_field();
					field_byte(c);
				end
			end
			FM_SEP: begin
				// In paragraph mode a newline inside a record also splits fields.
				is_sep = (c == fld_sep) || (rec_mode == RM_PARA && c == CH_NL);
				if (first || !fld_open)
					open_field();
				if (is_sep) begin
					close_field();
					open_field();
				end else begin
					field_byte(c);
				end
			end
			default: begin
				open_field();
				field_byte(c);
				close_field();
			end
		endcase
	endtask

	task automatic split_beat(input logic [7:0] c, input logic eoi);
		beat_events.delete();
		if (eoi) begin
			if (nl_held && rec_mode == RM_SEP) begin
				nl_held = 1'b0;
				take_byte(CH_NL);
			end
			nl_held = 1'b0;
			if (rec_open)
				close_record();
		end else if (rec_mode == RM_PARA) begin
			if (nl_held) begin
				nl_held = 1'b0;
				if (c == CH_NL) begin
					close_record();
				end else begin
					take_byte(CH_NL);
					take_byte(c);
				end
			end else if (c == CH_NL) begin
				if (rec_open)
					nl_held = 1'b1;
			end else begin
				take_byte(c);
			end
		end else begin
			// A newline held over from paragraph mode now counts as a plain byte.
			if (nl_held) begin
				nl_held = 1'b0;
				take_byte(CH_NL);
			end
			if (c == rec_sep)
				close_record();
			else
				take_byte(c);
		end
		if (beat_events.size() > 0)
			beat_events[beat_events.size() - 1].last = 1'b1;
		foreach (beat_events[i])
			expected_events.insert(expected_events.size(), beat_events[i]);
	endtask

	task automatic check_event();
		split_evt_t want;
		if (expected_events.size() == 0) begin
			report_mismatch("beat with nothing expected", m_tdata, 32'h0);
		end else begin
			want = expected_events.pop_front();
			if (m_tuser !== want.ev.event_kind)
				report_mismatch("event_kind", 32'(m_tuser), 32'(want.ev.event_kind));
			if (m_tdata[7:0] !== want.ev.out_byte)
				report_mismatch("out_byte", 32'(m_tdata[7:0]), 32'(want.ev.out_byte));
			if (m_tdata[16:8] !== want.ev.field_number)
				report_mismatch("field_number", 32'(m_tdata[16:8]),
					32'(want.ev.field_number));
			if (m_tdata[25:17] !== want.ev.field_count)
				report_mismatch("field_count", 32'(m_tdata[25:17]),
					32'(want.ev.field_count));
			if (m_tdata[26] !== want.ev.fields_overflow)
				report_mismatch("fields_overflow", 32'(m_tdata[26]),
					32'(want.ev.fields_overflow));
			if (m_tlast !== want.last)
				report_mismatch("last", 32'(m_tlast), 32'(want.last));
		end
		events_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_mode = RM_SEP;
			rec_sep  = CH_NL;
			fld_mode = FM_WS;
			fld_sep  = CH_SP;
			rec_open = 1'b0;
			fld_open = 1'b0;
			nl_held  = 1'b0;
			ovf      = 1'b0;
			nfields  = 0;
			expected_events.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_RECORD_MODE: rec_mode = cfg_wdata[0];
					CFG_RECORD_SEP:  rec_sep  = cfg_wdata;
					CFG_FIELD_MODE:  fld_mode = cfg_wdata[1:0];
					CFG_FIELD_SEP:   fld_sep  = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				split_beat(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				check_event();
		end
		outstanding = expected_events.size();
	end

endmodule

/* tb/tb.sv */
// Testbench top for the record and field splitter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;
	import arfs_pkg::*;

	localparam int unsigned MAX_FIELDS      = 256;
	localparam int          QUIET_LIMIT     = 2000;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam int          SEG_ITEMS       = 3;
	localparam logic [1:0]  FM_EACH         = 2'd2;
	localparam logic [1:0]  FM_UNUSED       = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [31:0]           m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int                    mismatches;
	int                    outstanding;
	int                    send_idle = 0;
	int                    recv_idle = 0;
	int                    quiet_cycles = 0;
	logic                  stall_request = 1'b0;
	logic                  hold_done = 1'b0;
	cfg_t                  cur_cfg;

	// Settings swept by the random part; separator extremes included.
	cfg_t mode_table [9] = '{
		'{RM_SEP,  CH_NL, FM_WS,     CH_SP},
		'{RM_PARA, CH_NL, FM_SEP,    8'h2C},
		'{RM_SEP,  8'h00, FM_SEP,    8'hFF},
		'{RM_SEP,  8'hFF, FM_EACH,   8'h00},
		'{RM_PARA, 8'h3B, FM_UNUSED, 8'h3A},
		'{RM_SEP,  8'h3B, FM_SEP,    CH_TAB},
		'{RM_PARA, 8'h00, FM_WS,     8'hFF},
		'{RM_SEP,  8'h7C, FM_UNUSED, 8'h2C},
		'{RM_PARA, 8'hFF, FM_SEP,    CH_SP}
	};

	always #2 clk = ~clk;

	awk_record_field_splitter #(
		.MAX_FIELDS (MAX_FIELDS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	field_split_checker #(
		.MAX_FIELDS (MAX_FIELDS)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	task automatic send_item(input logic [7:0] b, input logic eoi);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tlast  = eoi;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_item(text[i], 1'b0);
	endtask

	// Stop offering beats, let every expected event out, then idle before returning.
	task automatic pause_until_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic set_config(input cfg_t c);
		write_reg(CFG_RECORD_MODE, {7'b0, c.record_mode});
		write_reg(CFG_RECORD_SEP,  c.record_sep);
		write_reg(CFG_FIELD_MODE,  {6'b0, c.field_mode});
		write_reg(CFG_FIELD_SEP,   c.field_sep);
		cur_cfg = c;
	endtask

	task automatic set_idling(input int profile);
		case (profile)
			0: begin
				send_idle = 37;
				recv_idle = 50;
			end
			1: begin
				send_idle = 50;
				recv_idle = 37;
			end
			default: begin
				send_idle = 0;
				recv_idle = 0;
			end
		endcase
	endtask

	// Text-like bytes, weighted toward the characters that steer the splitter.
	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return CH_NL;
		else if (r < 25)
			return CH_SP;
		else if (r < 30)
			return CH_TAB;
		else if (r < 40)
			return cur_cfg.record_sep;
		else if (r < 50)
			return cur_cfg.field_sep;
		else if (r < 65)
			return 8'($urandom_range(255));
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request && !hold_done) begin
				m_tready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			m_tready = ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'h00;
		s_tlast   = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = CFG_RECORD_MODE;
		cfg_wdata = 8'h00;
		cur_cfg   = '{RM_SEP, CH_NL, FM_WS, CH_SP};
		set_idling(0);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Default settings: whitespace fields, an empty record, extreme bytes,
		// and a record closed by end of input.
		send_text("a \tb\n");
		send_text("\n");
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h00, 1'b1);

		// Separator fields, with adjacent separators giving empty fields.
		pause_until_drained();
		write_reg(CFG_FIELD_MODE, {6'b0, FM_SEP});
		write_reg(CFG_FIELD_SEP, ",");
		send_text(",,a,\n");

		// Paragraph mode: leading newlines, newline as field split, blank line.
		// The record is left with a newline held when the mode flips back.
		pause_until_drained();
		write_reg(CFG_RECORD_MODE, {7'b0, RM_PARA});
		send_text("\nab\ncd\n\nq\n");
		pause_until_drained();
		write_reg(CFG_RECORD_MODE, {7'b0, RM_SEP});
		send_text("y");
		send_item(8'h00, 1'b1);

		// One record with more fields than the limit. Bytes within the limit make two events,
		// so the long receiver hold-off here fills the block and stalls the input.
		pause_until_drained();
		set_config('{RM_SEP, CH_NL, FM_EACH, CH_SP});
		stall_request = 1'b1;
		for (int i = 0; i < MAX_FIELDS + 2; i++) begin
			set_idling(int'((3 * i) / (MAX_FIELDS + 2)));
			send_item(8'($urandom_range(8'h0B, 8'hFF)), 1'b0);
		end
		send_item(CH_NL, 1'b0);

		for (int seg = 0; seg < 9; seg++) begin
			pause_until_drained();
			set_config(mode_table[seg]);
			set_idling(seg / 3);
			repeat (SEG_ITEMS) send_item(pick_text_byte(), $urandom_range(99) < 4);
		end

		pause_until_drained();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* awk_record_field_splitter.f */
sv/arfs_pkg.sv
sv/arfs_step.sv
sv/arfs_evq.sv
sv/awk_record_field_splitter.sv
tb/field_split_checker.sv
tb/tb.sv
